// ===== sv/nlla_pkg.sv =====
// Package for the newline line assembler: sizes, character codes and the
// transaction types passed between the front end, command queue and back end.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nlla_pkg;

    localparam int LINE_DEPTH = 64;
    localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LINE_DEPTH + 1);
    localparam int RAM_AW     = IDX_W + 1;
    localparam int RAM_DEPTH  = 2 * (2 ** IDX_W);
    localparam int CQ_DEPTH   = 2;
    localparam int OB_DEPTH   = 2;

    localparam int BYTE_W = 8;
    localparam int CFG_W  = 7;
    localparam int LEN_W  = 7;
    localparam int CTR_W  = 32;

    localparam logic [BYTE_W-1:0] CHAR_CR   = 8'd13;
    localparam logic [BYTE_W-1:0] CHAR_LF   = 8'd10;
    localparam logic [CFG_W-1:0]  MAX_RESET = 7'd64;

    // one completed line waiting to be read out of its bank
    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] len;
        logic [CTR_W-1:0] frames;
        logic [CTR_W-1:0] ovf;
        logic [CTR_W-1:0] bytes;
    } t_cmd;

    // bank handed back to the front end
    typedef struct packed {
        logic valid;
        logic bank;
    } t_rel;

    typedef struct packed {
        logic              en;
        logic [RAM_AW-1:0] addr;
        logic [BYTE_W-1:0] data;
    } t_wr;

endpackage

`default_nettype wire

// ===== sv/nlla_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module nlla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/nlla_front.sv =====
// Front end: takes received bytes, keeps the counters and the line length,
// writes line bytes into the current bank and queues completed lines.
// Depends on nlla_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nlla_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [nlla_pkg::BYTE_W-1:0]   i_rx_byte,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [nlla_pkg::CFG_W-1:0]    i_cfg_data,
    output nlla_pkg::t_wr                      o_wr,
    output logic                               o_cmd_push,
    output nlla_pkg::t_cmd                     o_cmd,
    input  wire logic                          i_cq_full,
    input  wire nlla_pkg::t_rel                i_rel
);

    logic [nlla_pkg::CNT_W-1:0] r_line_cnt, n_line_cnt;
    logic                       r_bank, n_bank;
    logic [1:0]                 r_busy, n_busy;
    logic [nlla_pkg::CTR_W-1:0] r_frames, n_frames;
    logic [nlla_pkg::CTR_W-1:0] r_ovf, n_ovf;
    logic [nlla_pkg::CTR_W-1:0] r_bytes, n_bytes;
    logic [nlla_pkg::CFG_W-1:0] r_max, n_max;

    logic                       accept;
    logic [nlla_pkg::CFG_W-1:0] eff_max;

    assign full        = r_busy[r_bank] || i_cq_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;

    always_comb begin
        eff_max = r_max;
        if (r_max == '0) begin
            eff_max = nlla_pkg::CFG_W'(1);
        end else if (r_max > nlla_pkg::CFG_W'(nlla_pkg::LINE_DEPTH)) begin
            eff_max = nlla_pkg::CFG_W'(nlla_pkg::LINE_DEPTH);
        end
    end

    always_comb begin
        n_line_cnt = r_line_cnt;
        n_bank     = r_bank;
        n_busy     = r_busy;
        n_frames   = r_frames;
        n_ovf      = r_ovf;
        n_bytes    = r_bytes;
        n_max      = r_max;
        o_wr.en    = 1'b0;
        o_wr.addr  = {r_bank, r_line_cnt[nlla_pkg::IDX_W-1:0]};
        o_wr.data  = i_rx_byte;
        o_cmd_push = 1'b0;
        o_cmd.bank   = r_bank;
        o_cmd.len    = r_line_cnt;
        o_cmd.frames = r_frames + 1'b1;
        o_cmd.ovf    = r_ovf;
        o_cmd.bytes  = r_bytes + 1'b1;

        if (accept) begin
            n_bytes = r_bytes + 1'b1;
            if (i_rx_byte == nlla_pkg::CHAR_LF) begin
                if (r_line_cnt != '0) begin
                    n_frames       = r_frames + 1'b1;
                    o_cmd_push     = 1'b1;
                    n_line_cnt     = '0;
                    n_bank         = ~r_bank;
                    n_busy[r_bank] = 1'b1;
                end
            end else if (i_rx_byte != nlla_pkg::CHAR_CR) begin
                if (nlla_pkg::CFG_W'(r_line_cnt) >= eff_max) begin
                    n_ovf      = r_ovf + 1'b1;
                    n_line_cnt = '0;
                end else begin
                    o_wr.en    = 1'b1;
                    n_line_cnt = r_line_cnt + 1'b1;
                end
            end
        end

        if (i_rel.valid) begin
            n_busy[i_rel.bank] = 1'b0;
        end

        if (i_cfg_valid) begin
            n_max = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_cnt <= '0;
            r_bank     <= 1'b0;
            r_busy     <= '0;
            r_frames   <= '0;
            r_ovf      <= '0;
            r_bytes    <= '0;
            r_max      <= nlla_pkg::MAX_RESET;
        end else begin
            r_line_cnt <= n_line_cnt;
            r_bank     <= n_bank;
            r_busy     <= n_busy;
            r_frames   <= n_frames;
            r_ovf      <= n_ovf;
            r_bytes    <= n_bytes;
            r_max      <= n_max;
        end
    end

    a_rel_of_busy_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rel.valid |-> r_busy[i_rel.bank])
        else $error("bank released that was not in use");

    a_cmd_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_push |-> !i_cq_full)
        else $error("line queued into a full command queue");

    a_line_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        nlla_pkg::CFG_W'(r_line_cnt) <= nlla_pkg::CFG_W'(nlla_pkg::LINE_DEPTH))
        else $error("line length beyond bank depth");

endmodule

`default_nettype wire

// ===== sv/nlla_cmdq.sv =====
// Two-entry queue of completed-line transactions between front and back end.
// Depends on nlla_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nlla_cmdq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire nlla_pkg::t_cmd i_cmd,
    output logic                o_full,
    input  wire logic           i_pop,
    output nlla_pkg::t_cmd      o_head,
    output logic                o_empty
);

    nlla_pkg::t_cmd r_q [nlla_pkg::CQ_DEPTH];
    logic           r_wr, r_rd;
    logic [1:0]     r_cnt;
    logic           do_push, do_pop;

    assign o_full  = (r_cnt == 2'(nlla_pkg::CQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_q[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_q[r_wr] <= i_cmd;
                r_wr      <= ~r_wr;
            end
            if (do_pop) begin
                r_rd <= ~r_rd;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/nlla_back.sv =====
// Back end: reads a queued line out of its bank one byte at a time and
// presents the results through a two-entry output buffer.
// Depends on nlla_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nlla_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cq_empty,
    input  wire nlla_pkg::t_cmd               i_cq_head,
    output logic                              o_cq_pop,
    output logic                              o_rd_en,
    output logic      [nlla_pkg::RAM_AW-1:0]  o_rd_addr,
    input  wire logic [nlla_pkg::BYTE_W-1:0]  i_rd_data,
    output nlla_pkg::t_rel                    o_rel,
    input  wire logic                         pop,
    output logic                              empty,
    output logic      [nlla_pkg::BYTE_W-1:0]  o_line_byte,
    output logic                              o_last_of_line,
    output logic      [nlla_pkg::LEN_W-1:0]   o_line_length,
    output logic      [nlla_pkg::CTR_W-1:0]   o_frames_received,
    output logic      [nlla_pkg::CTR_W-1:0]   o_overflow_errors,
    output logic      [nlla_pkg::CTR_W-1:0]   o_bytes_received
);

    typedef enum logic {
        S_IDLE,
        S_BURST
    } t_state;

    typedef struct packed {
        logic [nlla_pkg::BYTE_W-1:0] data;
        logic                        last;
        logic [nlla_pkg::LEN_W-1:0]  len;
        logic [nlla_pkg::CTR_W-1:0]  frames;
        logic [nlla_pkg::CTR_W-1:0]  ovf;
        logic [nlla_pkg::CTR_W-1:0]  bytes;
    } t_res;

    t_state                     r_state;
    nlla_pkg::t_cmd             r_cmd;
    logic [nlla_pkg::CNT_W-1:0] r_idx;
    logic                       r_inflight, r_inflight_last;
    t_res                       r_ob [nlla_pkg::OB_DEPTH];
    logic                       r_ob_wr, r_ob_rd;
    logic [1:0]                 r_ob_cnt;

    logic room, issue, last_issue, ob_pop;

    // keep a buffer slot for the read already in flight
    assign room       = ({1'b0, r_ob_cnt} + 3'(r_inflight)) < 3'(nlla_pkg::OB_DEPTH);
    assign issue      = (r_state == S_BURST) && room;
    assign last_issue = issue && (nlla_pkg::CNT_W'(r_idx + 1'b1) == r_cmd.len);
    assign o_cq_pop   = (r_state == S_IDLE) && !i_cq_empty;
    assign ob_pop     = pop && !empty;

    assign o_rd_en     = issue;
    assign o_rd_addr   = {r_cmd.bank, r_idx[nlla_pkg::IDX_W-1:0]};
    assign o_rel.valid = last_issue;
    assign o_rel.bank  = r_cmd.bank;

    assign empty             = (r_ob_cnt == '0);
    assign o_line_byte       = r_ob[r_ob_rd].data;
    assign o_last_of_line    = r_ob[r_ob_rd].last;
    assign o_line_length     = r_ob[r_ob_rd].len;
    assign o_frames_received = r_ob[r_ob_rd].frames;
    assign o_overflow_errors = r_ob[r_ob_rd].ovf;
    assign o_bytes_received  = r_ob[r_ob_rd].bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_inflight      <= 1'b0;
            r_inflight_last <= 1'b0;
            r_ob_wr         <= 1'b0;
            r_ob_rd         <= 1'b0;
            r_ob_cnt        <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_cq_pop) begin
                        r_cmd   <= i_cq_head;
                        r_idx   <= '0;
                        r_state <= S_BURST;
                    end
                end
                S_BURST: begin
                    if (issue) begin
                        r_idx <= r_idx + 1'b1;
                        if (last_issue) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            r_inflight      <= issue;
            r_inflight_last <= last_issue;

            if (r_inflight) begin
                r_ob[r_ob_wr] <= '{data:   i_rd_data,
                                   last:   r_inflight_last,
                                   len:    nlla_pkg::LEN_W'(r_cmd.len),
                                   frames: r_cmd.frames,
                                   ovf:    r_cmd.ovf,
                                   bytes:  r_cmd.bytes};
                r_ob_wr <= ~r_ob_wr;
            end
            if (ob_pop) begin
                r_ob_rd <= ~r_ob_rd;
            end
            case ({r_inflight, ob_pop})
                2'b10:   r_ob_cnt <= r_ob_cnt + 1'b1;
                2'b01:   r_ob_cnt <= r_ob_cnt - 1'b1;
                default: r_ob_cnt <= r_ob_cnt;
            endcase
        end
    end

    a_slot_reserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight |-> (r_ob_cnt < 2'(nlla_pkg::OB_DEPTH)))
        else $error("read data returned with no buffer slot");

    a_ob_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ob_cnt <= 2'(nlla_pkg::OB_DEPTH))
        else $error("output buffer count out of range");

    a_read_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |-> (r_idx < r_cmd.len))
        else $error("line read past its length");

endmodule

`default_nettype wire

// ===== sv/newline_line_assembler_unit.sv =====
// Newline line assembler top level: front end, command queue, two-bank line RAM, back end.
// Bytes are taken one per cycle unless full, which rises only while both banks await readout.
// A completed line passes the command queue, back-end command register, RAM read register
// and two-entry output buffer; a read issues only while the buffer has a slot free for it.
// Synchronous active-low reset clears counters and line length, maximum returns to 64.
// Depends on nlla_pkg, nlla_front, nlla_cmdq, nlla_ram, nlla_back.
`timescale 1ns / 1ps
`default_nettype none

module newline_line_assembler_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic [nlla_pkg::BYTE_W-1:0]  i_rx_byte,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [nlla_pkg::CFG_W-1:0]   i_cfg_data,
    input  wire logic                         pop,
    output logic                              empty,
    output logic      [nlla_pkg::BYTE_W-1:0]  o_line_byte,
    output logic                              o_last_of_line,
    output logic      [nlla_pkg::LEN_W-1:0]   o_line_length,
    output logic      [nlla_pkg::CTR_W-1:0]   o_frames_received,
    output logic      [nlla_pkg::CTR_W-1:0]   o_overflow_errors,
    output logic      [nlla_pkg::CTR_W-1:0]   o_bytes_received
);

    nlla_pkg::t_wr              wr;
    nlla_pkg::t_cmd             cmd_in, cmd_head;
    nlla_pkg::t_rel             rel;
    logic                       cmd_push, cq_full, cq_pop, cq_empty;
    logic                       rd_en;
    logic [nlla_pkg::RAM_AW-1:0] rd_addr;
    logic [nlla_pkg::BYTE_W-1:0] rd_data;

    nlla_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_rx_byte   (i_rx_byte),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_wr        (wr),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd_in),
        .i_cq_full   (cq_full),
        .i_rel       (rel)
    );

    nlla_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (cq_full),
        .i_pop   (cq_pop),
        .o_head  (cmd_head),
        .o_empty (cq_empty)
    );

    nlla_ram #(
        .WIDTH (nlla_pkg::BYTE_W),
        .DEPTH (nlla_pkg::RAM_DEPTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (wr.en),
        .i_waddr (wr.addr),
        .i_wdata (wr.data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    nlla_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cq_empty        (cq_empty),
        .i_cq_head         (cmd_head),
        .o_cq_pop          (cq_pop),
        .o_rd_en           (rd_en),
        .o_rd_addr         (rd_addr),
        .i_rd_data         (rd_data),
        .o_rel             (rel),
        .pop               (pop),
        .empty             (empty),
        .o_line_byte       (o_line_byte),
        .o_last_of_line    (o_last_of_line),
        .o_line_length     (o_line_length),
        .o_frames_received (o_frames_received),
        .o_overflow_errors (o_overflow_errors),
        .o_bytes_received  (o_bytes_received)
    );

endmodule

`default_nettype wire
